FILE: hdl/jcc_pkg.sv
// Shared widths, payload structures and constants for the Jacobi constant pipeline.
package jcc_pkg;

  localparam int CoordW = 32;
  localparam int SqW    = 66;
  localparam int RootW  = 33;
  localparam int RemW   = 36;
  localparam int QuadW  = 43;
  localparam int NumW   = 50;
  localparam int DRemW  = 34;
  localparam int JacW   = 48;
  localparam int SumW   = 53;
  localparam int FracW  = 24;
  localparam int PotShift = 17;

  localparam logic signed [JacW-1:0] JacMax = {1'b0, {(JacW-1){1'b1}}};
  localparam logic signed [JacW-1:0] JacMin = {1'b1, {(JacW-1){1'b0}}};

  typedef struct packed {
    logic [SqW-1:0]          sum_one;
    logic [SqW-1:0]          sum_two;
    logic signed [QuadW-1:0] quad;
  } front_t;

  typedef struct packed {
    logic [RootW-1:0]        r1;
    logic [RootW-1:0]        r2;
    logic signed [QuadW-1:0] quad;
  } root_t;

  typedef struct packed {
    logic [RootW-1:0]        r1;
    logic [RootW-1:0]        r2;
    logic [NumW-1:0]         t1;
    logic [NumW-1:0]         t2;
    logic signed [QuadW-1:0] quad;
  } quot_t;

endpackage

FILE: hdl/jcc_front.sv
// Front end: offsets, magnitudes, squares and the sums of squares in three stages.
module jcc_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           en,
  input  logic                           in_valid,
  input  logic [jcc_pkg::CoordW-1:0]     mass_ratio,
  input  logic [jcc_pkg::CoordW-1:0]     pos_x,
  input  logic [jcc_pkg::CoordW-1:0]     pos_y,
  input  logic [jcc_pkg::CoordW-1:0]     pos_z,
  input  logic [jcc_pkg::CoordW-1:0]     vel_x,
  input  logic [jcc_pkg::CoordW-1:0]     vel_y,
  input  logic [jcc_pkg::CoordW-1:0]     vel_z,
  output logic                           out_valid,
  output jcc_pkg::front_t                out_data
);

  localparam int W = jcc_pkg::CoordW;

  function automatic logic [W-1:0] mag34(input logic [W+1:0] v);
    logic [W+1:0] a;
    a = v[W+1] ? (~v + 1'b1) : v;
    return a[W-1:0];
  endfunction

  function automatic logic [W-1:0] mag32(input logic [W-1:0] v);
    return v[W-1] ? (~v + 1'b1) : v;
  endfunction

  logic [W:0]      mu_sum;
  logic [W-8:0]    mu24;
  logic [W+1:0]    dx1;
  logic [W+1:0]    dx2;

  logic [2:0]      vld;
  logic [W-1:0]    m_dx1, m_dx2, m_x, m_y, m_z, m_vx, m_vy, m_vz;
  logic [2*W-1:0]  q_dx1, q_dx2, q_x, q_y, q_z, q_vx, q_vy, q_vz;

  logic [2*W:0]    pos2;
  logic [2*W+1:0]  vel2;
  logic [2*W+2:0]  diff;

  always_comb begin
    mu_sum = {1'b0, mass_ratio} + (W+1)'(128);
    mu24   = mu_sum[W:8];
    dx1    = {{2{pos_x[W-1]}}, pos_x} + {{9{1'b0}}, mu24};
    dx2    = dx1 - (W+2)'(1 << jcc_pkg::FracW);
    pos2   = {1'b0, q_x} + {1'b0, q_y};
    vel2   = {2'b0, q_vx} + {2'b0, q_vy} + {2'b0, q_vz};
    diff   = {2'b0, pos2} - {1'b0, vel2};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_dx1 <= mag34(dx1);
      m_dx2 <= mag34(dx2);
      m_x   <= mag32(pos_x);
      m_y   <= mag32(pos_y);
      m_z   <= mag32(pos_z);
      m_vx  <= mag32(vel_x);
      m_vy  <= mag32(vel_y);
      m_vz  <= mag32(vel_z);
      q_dx1 <= m_dx1 * m_dx1;
      q_dx2 <= m_dx2 * m_dx2;
      q_x   <= m_x * m_x;
      q_y   <= m_y * m_y;
      q_z   <= m_z * m_z;
      q_vx  <= m_vx * m_vx;
      q_vy  <= m_vy * m_vy;
      q_vz  <= m_vz * m_vz;
      out_data.sum_one <= {2'b0, q_dx1} + {2'b0, q_y} + {2'b0, q_z};
      out_data.sum_two <= {2'b0, q_dx2} + {2'b0, q_y} + {2'b0, q_z};
      out_data.quad    <= diff[2*W+2:jcc_pkg::FracW];
    end
  end

  assign out_valid = vld[2];

endmodule

FILE: hdl/jcc_sqrt.sv
// Pipelined integer square root of both distance sums, one result bit per stage.
module jcc_sqrt (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  jcc_pkg::front_t  in_data,
  output logic             out_valid,
  output jcc_pkg::root_t   out_data
);

  localparam int N  = jcc_pkg::RootW;
  localparam int SW = jcc_pkg::SqW;
  localparam int RW = jcc_pkg::RemW;

  typedef struct packed {
    logic [RW-1:0] rem;
    logic [N-1:0]  root;
  } sq_step_t;

  function automatic sq_step_t sq_step(input logic [RW-1:0] rem, input logic [N-1:0] root,
                                       input logic [1:0] pair);
    sq_step_t     r;
    logic [RW-1:0] sh;
    logic [RW-1:0] trial;
    sh    = {rem[RW-3:0], pair};
    trial = {root[RW-4:0], 2'b01};
    if (sh >= trial) begin
      r.rem  = sh - trial;
      r.root = {root[N-2:0], 1'b1};
    end else begin
      r.rem  = sh;
      r.root = {root[N-2:0], 1'b0};
    end
    return r;
  endfunction

  logic                        vld  [0:N];
  logic [SW-1:0]               a1   [0:N];
  logic [SW-1:0]               a2   [0:N];
  logic [RW-1:0]               rem1 [0:N];
  logic [RW-1:0]               rem2 [0:N];
  logic [N-1:0]                rt1  [0:N];
  logic [N-1:0]                rt2  [0:N];
  logic signed [jcc_pkg::QuadW-1:0] qd [0:N];

  always_comb begin
    vld[0]  = in_valid;
    a1[0]   = in_data.sum_one;
    a2[0]   = in_data.sum_two;
    rem1[0] = '0;
    rem2[0] = '0;
    rt1[0]  = '0;
    rt2[0]  = '0;
    qd[0]   = in_data.quad;
  end

  for (genvar k = 0; k < N; k++) begin : g_stage
    sq_step_t s1, s2;
    assign s1 = sq_step(rem1[k], rt1[k], a1[k][2*(N-1-k)+1 -: 2]);
    assign s2 = sq_step(rem2[k], rt2[k], a2[k][2*(N-1-k)+1 -: 2]);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        a1[k+1]   <= a1[k];
        a2[k+1]   <= a2[k];
        rem1[k+1] <= s1.rem;
        rem2[k+1] <= s2.rem;
        rt1[k+1]  <= s1.root;
        rt2[k+1]  <= s2.root;
        qd[k+1]   <= qd[k];
      end
    end
  end

  assign out_valid     = vld[N];
  assign out_data.r1   = rt1[N];
  assign out_data.r2   = rt2[N];
  assign out_data.quad = qd[N];

endmodule

FILE: hdl/jcc_div.sv
// Pipelined restoring division for both potential terms, one quotient bit per stage.
module jcc_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  jcc_pkg::root_t                in_data,
  input  logic [jcc_pkg::CoordW-1:0]    mass_ratio,
  output logic                          out_valid,
  output jcc_pkg::quot_t                out_data
);

  localparam int M  = jcc_pkg::NumW;
  localparam int D  = jcc_pkg::RootW;
  localparam int RW = jcc_pkg::DRemW;
  localparam int W  = jcc_pkg::CoordW;

  typedef struct packed {
    logic [D-1:0] rem;
    logic [M-1:0] quo;
  } dv_step_t;

  function automatic dv_step_t dv_step(input logic [D-1:0] rem, input logic [M-1:0] quo,
                                       input logic [D-1:0] den, input logic nbit);
    dv_step_t      r;
    logic [RW-1:0] sh;
    logic [RW-1:0] diff;
    sh   = {rem, nbit};
    diff = sh - {1'b0, den};
    if (sh >= {1'b0, den}) begin
      r.rem = diff[D-1:0];
      r.quo = {quo[M-2:0], 1'b1};
    end else begin
      r.rem = sh[D-1:0];
      r.quo = {quo[M-2:0], 1'b0};
    end
    return r;
  endfunction

  logic [W:0]      mu_c;
  logic            vld [0:M];
  logic [M-1:0]    n1  [0:M];
  logic [M-1:0]    n2  [0:M];
  logic [D-1:0]    rm1 [0:M];
  logic [D-1:0]    rm2 [0:M];
  logic [M-1:0]    qo1 [0:M];
  logic [M-1:0]    qo2 [0:M];
  jcc_pkg::root_t  sb  [0:M];

  always_comb begin
    mu_c   = {1'b1, {W{1'b0}}} - {1'b0, mass_ratio};
    vld[0] = in_valid;
    n1[0]  = {mu_c, {jcc_pkg::PotShift{1'b0}}};
    n2[0]  = {1'b0, mass_ratio, {jcc_pkg::PotShift{1'b0}}};
    rm1[0] = '0;
    rm2[0] = '0;
    qo1[0] = '0;
    qo2[0] = '0;
    sb[0]  = in_data;
  end

  for (genvar k = 0; k < M; k++) begin : g_stage
    dv_step_t s1, s2;
    assign s1 = dv_step(rm1[k], qo1[k], sb[k].r1, n1[k][M-1-k]);
    assign s2 = dv_step(rm2[k], qo2[k], sb[k].r2, n2[k][M-1-k]);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        n1[k+1]  <= n1[k];
        n2[k+1]  <= n2[k];
        rm1[k+1] <= s1.rem;
        rm2[k+1] <= s2.rem;
        qo1[k+1] <= s1.quo;
        qo2[k+1] <= s2.quo;
        sb[k+1]  <= sb[k];
      end
    end
  end

  assign out_valid     = vld[M];
  assign out_data.r1   = sb[M].r1;
  assign out_data.r2   = sb[M].r2;
  assign out_data.quad = sb[M].quad;
  assign out_data.t1   = qo1[M];
  assign out_data.t2   = qo2[M];

endmodule

FILE: hdl/jacobi_constant_cr3bp.sv
// Top level of the Jacobi constant pipeline: register, stages, final sum and output register.
//
// Channel   Direction  tdata fields (low bit first)                       tuser
// s_axis    in         pos_x, pos_y, pos_z, vel_x, vel_y, vel_z (192 b)   -
// m_axis    out        dist_primary_one, dist_primary_two, jacobi_value   saturated
// cfg       in         mass_ratio (32 b), written when cfg_wr_en is high  -
//
// One transaction is accepted per cycle while the output is not stalled; the path runs through three front
// stages, 33 square-root stages, 50 divider stages and the output register holding the sum.
// Reset clears every valid bit and the mass ratio; the payload registers are not reset.
// A stall on the output freezes the whole pipeline, so nothing is lost or repeated.
module jacobi_constant_cr3bp (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_wr_en,
  input  logic [31:0]  cfg_wr_data,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [191:0] s_tdata,   // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [119:0] m_tdata,   // dist_primary_one, dist_primary_two, jacobi_value, zero pad
  output logic         m_tuser    // saturated
);

  localparam int D = jcc_pkg::RootW;
  localparam int S = jcc_pkg::SumW;
  localparam int J = jcc_pkg::JacW;

  logic [31:0]      mass_ratio;
  logic             adv;
  logic             f_valid, r_valid, d_valid;
  jcc_pkg::front_t  f_data;
  jcc_pkg::root_t   r_data;
  jcc_pkg::quot_t   d_data;

  logic signed [S-1:0] sum;
  logic signed [J-1:0] jac_next;
  logic                sat_next;

  logic [D-1:0]        dist_one, dist_two;
  logic signed [J-1:0] jac;
  logic                sat;

  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      mass_ratio <= '0;
    end else if (cfg_wr_en) begin
      mass_ratio <= cfg_wr_data;
    end
  end

  jcc_front u_front (
    .clk(clk), .rst(rst), .en(adv), .in_valid(s_tvalid), .mass_ratio(mass_ratio),
    .pos_x(s_tdata[31:0]), .pos_y(s_tdata[63:32]), .pos_z(s_tdata[95:64]),
    .vel_x(s_tdata[127:96]), .vel_y(s_tdata[159:128]), .vel_z(s_tdata[191:160]),
    .out_valid(f_valid), .out_data(f_data)
  );

  jcc_sqrt u_sqrt (
    .clk(clk), .rst(rst), .en(adv), .in_valid(f_valid), .in_data(f_data),
    .out_valid(r_valid), .out_data(r_data)
  );

  jcc_div u_div (
    .clk(clk), .rst(rst), .en(adv), .in_valid(r_valid), .in_data(r_data),
    .mass_ratio(mass_ratio), .out_valid(d_valid), .out_data(d_data)
  );

  always_comb begin
    sum = S'(d_data.quad) + $signed({3'b0, d_data.t1}) + $signed({3'b0, d_data.t2});
    if (d_data.r1 == '0 || d_data.r2 == '0) begin
      jac_next = jcc_pkg::JacMax;
      sat_next = 1'b1;
    end else if (sum > S'(jcc_pkg::JacMax)) begin
      jac_next = jcc_pkg::JacMax;
      sat_next = 1'b1;
    end else if (sum < S'(jcc_pkg::JacMin)) begin
      jac_next = jcc_pkg::JacMin;
      sat_next = 1'b1;
    end else begin
      jac_next = sum[J-1:0];
      sat_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dist_one <= d_data.r1;
      dist_two <= d_data.r2;
      jac      <= jac_next;
      sat      <= sat_next;
    end
  end

  assign m_tdata = {6'b0, jac, dist_two, dist_one};
  assign m_tuser = sat;

  a_sat_value: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> jac == jcc_pkg::JacMax || jac == jcc_pkg::JacMin)
    else $error("saturated flag without a clipped value");

  a_zero_dist: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (dist_one == '0 || dist_two == '0) |-> m_tuser)
    else $error("zero distance without saturation");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("output valid straight after reset");

endmodule
